[hw/rtl/aps_pkg.sv]
// Package for the ADC pedestal statistics block: constants and codes.
package aps_pkg;
    localparam int DefNumSlots    = 32;
    localparam int DefNumChannels = 64;
    localparam int DefCountBits   = 24;

    localparam int ValueBits = 13;
    localparam int SlotBits  = 5;
    localparam int ChanBits  = 6;
    localparam int SlotLsb   = 27;
    localparam int ChanLsb   = 17;

    typedef enum logic [1:0] {
        CMD_ACCUM = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;
endpackage

[hw/rtl/adc_pedestal_statistics.sv]
// Top level of the ADC pedestal statistics block: stores, divider and root unit.
//
//  channel  dir  handshake                  payload
//  s_axis   in   s_axis_tvalid/tready       tdata {query_channel,query_slot,first,word,command}
//  m_axis   out  m_axis_tvalid/tready       tdata {sample_count,rms_q4,mean_value}
//  cfg      in   cfg_wr_en                  cfg_wr_data = adc_slot_mask
//
// A data word is read at the transfer, waits in ST_ARD, then is updated and
// written in ST_AUPD; a header, an ignored word or an unused command is handled in ST_IDLE.
// A read runs two restoring divisions and a bit-pair square root, one bit a cycle
// through the shared subtract unit, and squares the mean in ST_SQR; a zero count
// or an out-of-range query returns an all-zero result instead.
// After reset, and on a clear command, a clearing pass writes every entry, one per
// cycle; no transfer is accepted during the pass.
// A held result waits in the output register; the next item is taken only once
// it has gone.
module adc_pedestal_statistics #(
    parameter int NUM_SLOTS    = aps_pkg::DefNumSlots,
    parameter int NUM_CHANNELS = aps_pkg::DefNumChannels,
    parameter int COUNT_BITS   = aps_pkg::DefCountBits
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command[1:0], readout_word[33:2], first_of_event[34], query_slot[39:35],
    // query_channel[45:40], zero fill to 48
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // mean_value[12:0], rms_q4[29:13], sample_count[53:30], zero fill to 56
    output logic [55:0] m_axis_tdata
);
    import aps_pkg::*;

    localparam int Entries  = NUM_SLOTS * NUM_CHANNELS;
    localparam int IdxBits  = (Entries > 1) ? $clog2(Entries) : 1;
    localparam int SumBits  = COUNT_BITS + ValueBits;
    localparam int SqBits   = COUNT_BITS + 2 * ValueBits;
    localparam int QBits    = 2 * ValueBits;          // floor(sumsq/n) < 2^26
    localparam int RootIn   = 2 * ValueBits + 8 + 2;  // 256*d, even width
    localparam int RootBits = RootIn / 2;
    localparam int WBits    = SqBits + 1;
    localparam int CntBits  = $clog2(SqBits + 2);
    localparam int SChBits  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [COUNT_BITS-1:0] CountLimit = '1;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_ARD, ST_AUPD, ST_RRD, ST_RLOAD,
        ST_DIV1, ST_DIV2, ST_SQR, ST_ROOT, ST_OUT
    } state_t;

    // stores
    logic [COUNT_BITS-1:0] cnt_mem [Entries];
    logic [SumBits-1:0]    sum_mem [Entries];
    logic [SqBits-1:0]     sq_mem  [Entries];
    logic [COUNT_BITS-1:0] cnt_rd_reg;
    logic [SumBits-1:0]    sum_rd_reg;
    logic [SqBits-1:0]     sq_rd_reg;
    logic                  we;
    logic [IdxBits-1:0]    waddr, raddr;
    logic [COUNT_BITS-1:0] wcnt;
    logic [SumBits-1:0]    wsum;
    logic [SqBits-1:0]     wsq;

    state_t state_reg;
    logic [31:0]          mask_reg;
    logic [SlotBits-1:0]  prev_slot_reg;
    logic                 prev_valid_reg;
    logic [IdxBits-1:0]   idx_reg;
    logic [ValueBits-1:0] val_reg;
    logic                 zero_reg;
    logic [CntBits-1:0]   step_reg;
    logic [SqBits-1:0]    dvd_reg;   // dividend shifting into quotient
    logic [WBits-1:0]     rem_reg;   // partial remainder / root work word
    logic [SumBits-1:0]   mean_reg;
    logic [RootIn-1:0]    x_reg;
    logic [RootBits-1:0]  root_reg;
    logic [QBits-1:0]     q_reg;
    logic [55:0]          out_reg;
    logic                 ovalid_reg;

    // input fields
    logic [1:0]           in_cmd;
    logic [31:0]          in_word;
    logic                 in_first;
    logic [SlotBits-1:0]  in_qslot, w_slot;
    logic [ChanBits-1:0]  in_qchan, w_chan;
    assign in_cmd   = s_axis_tdata[1:0];
    assign in_word  = s_axis_tdata[33:2];
    assign in_first = s_axis_tdata[34];
    assign in_qslot = s_axis_tdata[39:35];
    assign in_qchan = s_axis_tdata[45:40];
    assign w_slot   = in_word[SlotLsb +: SlotBits];
    assign w_chan   = in_word[ChanLsb +: ChanBits];

    assign s_axis_tready = (state_reg == ST_IDLE) && !ovalid_reg;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = out_reg;

    logic accept;
    assign accept = s_axis_tvalid && s_axis_tready;

    // shared subtract unit: trial subtract of the divisor or root term
    logic [WBits-1:0] sub_a, sub_b, sub_d;
    logic             sub_ok;
    assign sub_d  = sub_a - sub_b;
    assign sub_ok = (sub_a >= sub_b);

    logic [WBits-1:0] rem_sh;
    logic [RootIn+1:0] root_trial;
    always_comb
    begin
        rem_sh = {rem_reg[WBits-2:0], dvd_reg[SqBits-1]};
        root_trial = '0;
        sub_a = rem_sh;
        sub_b = WBits'(cnt_rd_reg);
        if (state_reg == ST_ROOT)
        begin
            sub_a = {rem_reg[WBits-3:0], x_reg[RootIn-1 -: 2]};
            root_trial = (RootIn+2)'({root_reg, 2'b01});
            sub_b = WBits'(root_trial);
        end
    end

    // index helpers
    logic [IdxBits-1:0] w_idx, q_idx;
    assign w_idx = IdxBits'(w_slot * NUM_CHANNELS + SChBits'(w_chan));
    assign q_idx = IdxBits'(in_qslot * NUM_CHANNELS + SChBits'(in_qchan));

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            cnt_mem[waddr] <= wcnt;
            sum_mem[waddr] <= wsum;
            sq_mem[waddr]  <= wsq;
        end
        cnt_rd_reg <= cnt_mem[raddr];
        sum_rd_reg <= sum_mem[raddr];
        sq_rd_reg  <= sq_mem[raddr];
    end

    logic [2*ValueBits-1:0] vsq;
    assign vsq = val_reg * val_reg;

    always_comb
    begin
        raddr = accept ? ((in_cmd == CMD_READ) ? q_idx : w_idx) : idx_reg;
        we    = 1'b0;
        waddr = idx_reg;
        wcnt  = '0;
        wsum  = '0;
        wsq   = '0;
        if (state_reg == ST_CLEAR)
            we = 1'b1;
        else if (state_reg == ST_AUPD && cnt_rd_reg != CountLimit)
        begin
            we   = 1'b1;
            wcnt = cnt_rd_reg + 1'b1;
            wsum = sum_rd_reg + SumBits'(val_reg);
            wsq  = sq_rd_reg + SqBits'(vsq);
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            mask_reg       <= '0;
            prev_slot_reg  <= '0;
            prev_valid_reg <= 1'b0;
            idx_reg        <= '0;
            ovalid_reg     <= 1'b0;
            step_reg       <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                mask_reg <= cfg_wr_data;
            if (ovalid_reg && m_axis_tready)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                ST_CLEAR:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (32'(idx_reg) == Entries - 1)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (in_cmd)
                            CMD_ACCUM:
                            begin
                                logic pv;
                                pv = prev_valid_reg && !in_first;
                                if (in_first)
                                    prev_valid_reg <= 1'b0;
                                if (32'(w_slot) < NUM_SLOTS && mask_reg[w_slot])
                                begin
                                    if (!pv || prev_slot_reg != w_slot)
                                    begin
                                        prev_slot_reg  <= w_slot;
                                        prev_valid_reg <= 1'b1;
                                    end
                                    else if (32'(w_chan) < NUM_CHANNELS)
                                    begin
                                        idx_reg   <= w_idx;
                                        val_reg   <= in_word[ValueBits-1:0];
                                        state_reg <= ST_ARD;
                                    end
                                end
                            end
                            CMD_READ:
                            begin
                                idx_reg   <= q_idx;
                                zero_reg  <= !(32'(in_qslot) < NUM_SLOTS &&
                                               32'(in_qchan) < NUM_CHANNELS);
                                state_reg <= ST_RRD;
                            end
                            CMD_CLEAR:
                            begin
                                idx_reg   <= '0;
                                state_reg <= ST_CLEAR;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_ARD:  state_reg <= ST_AUPD;
                ST_AUPD: state_reg <= ST_IDLE;
                ST_RRD:  state_reg <= ST_RLOAD;
                ST_RLOAD:
                begin
                    if (zero_reg || cnt_rd_reg == '0)
                    begin
                        out_reg    <= '0;
                        ovalid_reg <= 1'b1;
                        state_reg  <= ST_IDLE;
                    end
                    else
                    begin
                        dvd_reg   <= SqBits'(sum_rd_reg) << (SqBits - SumBits);
                        rem_reg   <= '0;
                        step_reg  <= CntBits'(SumBits);
                        state_reg <= ST_DIV1;
                    end
                end
                ST_DIV1, ST_DIV2:
                begin
                    rem_reg  <= sub_ok ? sub_d : rem_sh;
                    dvd_reg  <= {dvd_reg[SqBits-2:0], sub_ok};
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == CntBits'(1))
                    begin
                        if (state_reg == ST_DIV1)
                        begin
                            mean_reg  <= SumBits'({dvd_reg[SqBits-2:0], sub_ok});
                            dvd_reg   <= sq_rd_reg;
                            rem_reg   <= '0;
                            step_reg  <= CntBits'(SqBits);
                            state_reg <= ST_DIV2;
                        end
                        else
                        begin
                            q_reg     <= QBits'({dvd_reg[SqBits-2:0], sub_ok});
                            state_reg <= ST_SQR;
                        end
                    end
                end
                ST_SQR:
                begin
                    logic [QBits-1:0] m2, dd;
                    m2 = mean_reg[ValueBits-1:0] * mean_reg[ValueBits-1:0];
                    dd = (q_reg >= m2) ? (q_reg - m2) : (m2 - q_reg);
                    x_reg     <= RootIn'({dd, 8'h00});
                    rem_reg   <= '0;
                    root_reg  <= '0;
                    step_reg  <= CntBits'(RootBits);
                    state_reg <= ST_ROOT;
                end
                ST_ROOT:
                begin
                    rem_reg  <= sub_ok ? sub_d : sub_a;
                    root_reg <= {root_reg[RootBits-2:0], sub_ok};
                    x_reg    <= {x_reg[RootIn-3:0], 2'b00};
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == CntBits'(1))
                        state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    out_reg <= {2'b00, 24'(cnt_rd_reg), 17'(root_reg),
                                mean_reg[ValueBits-1:0]};
                    ovalid_reg <= 1'b1;
                    state_reg  <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

[sim/adc_pedestal_statistics_test.sv]
// Testbench for the ADC pedestal statistics block: directed and random streams.
`timescale 1ns / 100ps

module adc_pedestal_statistics_test;
    import aps_pkg::*;

    localparam int Entries    = 32 * 64;
    localparam logic [23:0] CountLimit = '1;
    localparam int StallLimit = 20000;

    typedef struct packed {
        logic [12:0] mean_value;
        logic [16:0] rms_q4;
        logic [23:0] sample_count;
    } stats_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;

    // predictor state
    logic [31:0] slot_mask;
    logic [23:0] count_mem [Entries];
    logic [36:0] sum_mem [Entries];
    logic [49:0] square_mem [Entries];
    logic [4:0]  last_slot;
    logic        last_slot_seen;

    stats_t expected_stats [$];
    int     error_count = 0;
    int     read_count = 0;
    int     word_count = 0;
    int     idle_cycles = 0;
    bit     allow_gaps = 1'b1;

    adc_pedestal_statistics u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // zero all statistics
    task automatic clear_stats();
        for (int k = 0; k < Entries; k++)
        begin
            count_mem[k] = '0;
            sum_mem[k] = '0;
            square_mem[k] = '0;
        end
    endtask

    function automatic logic [63:0] isqrt64(logic [63:0] x);
        logic [63:0] root;
        logic [63:0] b;
        root = '0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= root + b)
            begin
                x = x - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        return root;
    endfunction

    // advance the predictor by one transfer
    task automatic predict_stats(cmd_t cmd, logic [31:0] word, logic first,
                                 logic [4:0] qs, logic [5:0] qc);
        logic [4:0]  slot;
        logic [10:0] idx;
        logic [63:0] n, mean, q, m2, d, r;
        stats_t      res;
        case (cmd)
            CMD_ACCUM:
            begin
                slot = word[31:27];
                if (first)
                    last_slot_seen = 1'b0;
                if (slot_mask[slot])
                begin
                    if (!last_slot_seen || last_slot != slot)
                    begin
                        last_slot = slot;
                        last_slot_seen = 1'b1;
                    end
                    else
                    begin
                        idx = {slot, word[22:17]};
                        if (count_mem[idx] < CountLimit)
                        begin
                            count_mem[idx] = count_mem[idx] + 24'd1;
                            sum_mem[idx] = sum_mem[idx] + 37'(word[12:0]);
                            square_mem[idx] = square_mem[idx]
                                              + 50'(word[12:0]) * 50'(word[12:0]);
                            word_count++;
                        end
                    end
                end
            end
            CMD_CLEAR: clear_stats();
            CMD_READ:
            begin
                idx = {qs, qc};
                n = 64'(count_mem[idx]);
                res = '0;
                if (n != 0)
                begin
                    mean = 64'(sum_mem[idx]) / n;
                    q = 64'(square_mem[idx]) / n;
                    m2 = mean * mean;
                    d = (q >= m2) ? q - m2 : m2 - q;
                    r = isqrt64(d << 8);
                    res.mean_value = mean[12:0];
                    res.rms_q4 = r[16:0];
                    res.sample_count = n[23:0];
                end
                expected_stats.push_back(res);
                read_count++;
            end
            default: ;
        endcase
    endtask

    // send one transfer, then update the predictor; valid stays up until a gap
    task automatic send_item(cmd_t cmd, logic [31:0] word, logic first = 1'b0,
                             logic [4:0] qs = '0, logic [5:0] qc = '0);
        int gap;
        if (allow_gaps && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(1, 9);
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata <= {2'b00, qc, qs, first, word, cmd};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_stats(cmd, word, first, qs, qc);
        @(negedge clk);
    endtask

    task automatic send_read(logic [4:0] qs, logic [5:0] qc);
        send_item(CMD_READ, $urandom, 1'($urandom_range(0, 1)), qs, qc);
    endtask

    function automatic logic [31:0] make_word(logic [4:0] slot, logic [5:0] chan,
                                              logic [12:0] val);
        logic [31:0] w;
        w = $urandom;
        w[31:27] = slot;
        w[22:17] = chan;
        w[12:0] = val;
        return w;
    endfunction

    // drop valid, hold until every expected result is back and the block is idle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (expected_stats.size() != 0 || !s_axis_tready)
            @(negedge clk);
    endtask

    task automatic write_mask(logic [31:0] mask);
        drain();
        cfg_wr_data <= mask;
        cfg_wr_en <= 1'b1;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        slot_mask = mask;
    endtask

    // one event: header plus data words for a slot
    task automatic send_event(logic [4:0] slot, int words, bit first);
        send_item(CMD_ACCUM, make_word(slot, 6'($urandom), 13'($urandom)), first);
        for (int k = 0; k < words; k++)
            send_item(CMD_ACCUM, make_word(slot, 6'($urandom_range(0, 3)),
                                           13'($urandom)));
    endtask

    task automatic test_directed();
        write_mask(32'h8000_0001);
        send_read(5'd0, 6'd0);
        send_item(CMD_ACCUM, make_word(5'd0, 6'd0, 13'h1FFF), 1'b1);
        send_item(CMD_ACCUM, make_word(5'd0, 6'd0, 13'h1FFF));
        send_item(CMD_ACCUM, make_word(5'd0, 6'd0, 13'h0000));
        send_item(CMD_ACCUM, make_word(5'd0, 6'd63, 13'h1FFF));
        // disabled slot leaves the run intact
        send_item(CMD_ACCUM, make_word(5'd5, 6'd0, 13'd77));
        send_item(CMD_ACCUM, make_word(5'd0, 6'd0, 13'd1));
        // slot change makes a header
        send_item(CMD_ACCUM, make_word(5'd31, 6'd63, 13'd9));
        send_item(CMD_ACCUM, make_word(5'd31, 6'd63, 13'h1FFF));
        send_item(CMD_ACCUM, 32'hFFFF_FFFF);
        // new event forgets the previous slot
        send_item(CMD_ACCUM, make_word(5'd31, 6'd63, 13'd3), 1'b1);
        send_item(CMD_NONE, 32'hFFFF_FFFF, 1'b1, 5'd31, 6'd63);
        send_read(5'd0, 6'd0);
        send_read(5'd0, 6'd63);
        send_read(5'd31, 6'd63);
        send_read(5'd5, 6'd0);
        send_item(CMD_CLEAR, 32'h0, 1'b0);
        send_read(5'd31, 6'd63);
        send_item(CMD_ACCUM, make_word(5'd31, 6'd63, 13'd42));
        send_read(5'd31, 6'd63);
    endtask

    task automatic test_random(int items, logic [31:0] mask);
        int sent;
        int r;
        write_mask(mask);
        sent = 0;
        while (sent < items)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                send_event(5'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3)),
                           $urandom_range(0, 8), $urandom_range(0, 3) != 0);
                sent += 5;
            end
            else if (r < 95)
            begin
                send_read(5'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3)),
                          6'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3)));
                sent++;
            end
            else if (r < 97)
            begin
                send_item(CMD_CLEAR, $urandom, 1'($urandom_range(0, 1)), 5'($urandom),
                          6'($urandom));
                sent++;
            end
            else
            begin
                send_item(cmd_t'($urandom_range(0, 3)), $urandom, 1'($urandom_range(0, 1)),
                          5'($urandom), 6'($urandom));
                sent++;
            end
        end
        // pause the stream until all results are in
        drain();
    endtask

    // sink: random stalls, compare each result with the oldest expectation
    always @(negedge clk)
    begin
        if (allow_gaps && $urandom_range(0, 7) == 0)
        begin
            m_axis_tready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        stats_t got;
        stats_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got.mean_value = m_axis_tdata[12:0];
            got.rms_q4 = m_axis_tdata[29:13];
            got.sample_count = m_axis_tdata[53:30];
            if (expected_stats.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, m_axis_tdata);
                error_count++;
            end
            else
            begin
                want = expected_stats.pop_front();
                if (got.mean_value != want.mean_value)
                begin
                    $display("%0t: mean_value expected %0d actual %0d", $time,
                             want.mean_value, got.mean_value);
                    error_count++;
                end
                if (got.rms_q4 != want.rms_q4)
                begin
                    $display("%0t: rms_q4 expected %0d actual %0d", $time,
                             want.rms_q4, got.rms_q4);
                    error_count++;
                end
                if (got.sample_count != want.sample_count)
                begin
                    $display("%0t: sample_count expected %0d actual %0d", $time,
                             want.sample_count, got.sample_count);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallLimit)
        begin
            $display("adc_pedestal_statistics_test: FAIL");
            $finish;
        end
    end

    initial
    begin
        slot_mask = '0;
        last_slot = '0;
        last_slot_seen = 1'b0;
        clear_stats();
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random(150, 32'h0000_000F);
        test_random(150, 32'hFFFF_FFFF);
        test_random(100, $urandom | 32'h1);
        allow_gaps = 1'b0;
        test_random(100, 32'h0000_0000 | 32'h5);
        drain();
        $display("Covered %0d reads and %0d accumulated data words", read_count, word_count);
        $display("over several slot masks, clears, event starts and idle commands.");
        if (error_count == 0)
            $display("adc_pedestal_statistics_test: PASS");
        else
            $display("adc_pedestal_statistics_test: FAIL");
        $finish;
    end
endmodule
